// ===== design/prd_pkg.sv =====
// ----------------------------------------------------------------------------
// Process record deque package
// Shared beat types, command codes and sizing defaults for the deque block.
// ----------------------------------------------------------------------------
package prd_pkg;

  // Sizing defaults handed to the top level.
  localparam int unsigned DepthDefault   = 64;
  localparam int unsigned PidBitsDefault = 16;

  // Fixed field widths of the channel beats.
  localparam int unsigned ModeW    = 3;
  localparam int unsigned PidW     = 16;
  localparam int unsigned PayloadW = 48;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned OccW     = 7;

  // Depth of the command queue between the front and the back; a power of two.
  localparam int unsigned CmdqDepth = 2;

  // Request codes carried in the mode field.
  localparam logic [ModeW-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [ModeW-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [ModeW-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [ModeW-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [ModeW-1:0] MODE_SEARCH     = 3'd4;
  localparam logic [ModeW-1:0] MODE_CLEAR      = 3'd5;

  // Result status codes.
  localparam logic [StatusW-1:0] STATUS_DONE  = 2'd0;
  localparam logic [StatusW-1:0] STATUS_FULL  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd2;

  // Classified operation handed from the front to the back.
  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_SEARCH,
    OP_CLEAR,
    OP_NOP
  } op_e;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SEARCH
  } state_e;

  typedef struct packed {
    logic [ModeW-1:0]    mode;
    logic [PidW-1:0]     record_pid;
    logic [PayloadW-1:0] record_payload;
  } in_beat_t;

  typedef struct packed {
    logic [StatusW-1:0]  status;
    logic [PidW-1:0]     out_pid;
    logic [PayloadW-1:0] out_payload;
    logic                found;
    logic [OccW-1:0]     occupancy;
  } out_beat_t;

  typedef struct packed {
    op_e                 op;
    logic [PidW-1:0]     pid;
    logic [PayloadW-1:0] payload;
  } cmd_t;

endpackage

// ===== design/prd_front.sv =====
// ----------------------------------------------------------------------------
// Process record deque front end
// Accepts request beats, classifies the mode and holds one command register.
// ----------------------------------------------------------------------------
module prd_front
  import prd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_beat_t in_beat_i,
  output logic     cmd_valid_o,
  input  logic     cmd_stall_i,
  output cmd_t     cmd_o
);

  logic valid_d, valid_q;
  cmd_t cmd_d, cmd_q;
  logic load;

  assign in_stall_o = valid_q && cmd_stall_i;
  assign load       = in_valid_i && !in_stall_o;

  // Modes six and seven become no-operation commands.
  always_comb begin
    cmd_d         = cmd_q;
    valid_d       = valid_q;
    if (valid_q && !cmd_stall_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d     = 1'b1;
      cmd_d.pid     = in_beat_i.record_pid;
      cmd_d.payload = in_beat_i.record_payload;
      case (in_beat_i.mode)
        MODE_PUSH_FRONT: cmd_d.op = OP_PUSH_FRONT;
        MODE_PUSH_BACK:  cmd_d.op = OP_PUSH_BACK;
        MODE_POP_FRONT:  cmd_d.op = OP_POP_FRONT;
        MODE_POP_BACK:   cmd_d.op = OP_POP_BACK;
        MODE_SEARCH:     cmd_d.op = OP_SEARCH;
        MODE_CLEAR:      cmd_d.op = OP_CLEAR;
        default:         cmd_d.op = OP_NOP;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

// ===== design/prd_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// Process record deque command queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module prd_cmd_fifo
  import prd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_stall_o,
  input  cmd_t wr_cmd_i,
  output logic rd_valid_o,
  input  logic rd_stall_i,
  output cmd_t rd_cmd_o
);

  localparam int unsigned PtrW = (CmdqDepth > 1) ? $clog2(CmdqDepth) : 1;
  localparam int unsigned CntW = $clog2(CmdqDepth + 1);

  cmd_t            slots_q [CmdqDepth];
  logic [PtrW-1:0] wptr_d, wptr_q, rptr_d, rptr_q;
  logic [CntW-1:0] cnt_d, cnt_q;
  logic            push, pop;

  assign wr_stall_o = (cnt_q == CntW'(CmdqDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_cmd_o   = slots_q[rptr_q];
  assign push       = wr_valid_i && !wr_stall_o;
  assign pop        = rd_valid_o && !rd_stall_i;

  always_comb begin
    wptr_d = push ? wptr_q + PtrW'(1) : wptr_q;
    rptr_d = pop ? rptr_q + PtrW'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wptr_q] <= wr_cmd_i;
    end
  end

endmodule

// ===== design/prd_back.sv =====
// ----------------------------------------------------------------------------
// Process record deque back end
// Ring store, head and count registers, search scan and the result register.
// ----------------------------------------------------------------------------
module prd_back
  import prd_pkg::*;
#(
  parameter int unsigned DEPTH    = DepthDefault,
  parameter int unsigned PID_BITS = PidBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_stall_o,
  input  cmd_t      cmd_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned MemW = PID_BITS + PayloadW;
  localparam logic [IdxW:0]   DepthIdx = (IdxW + 1)'(DEPTH);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(DEPTH - 1);

  // Ring position at a given offset from the head; both are below DEPTH.
  function automatic logic [IdxW-1:0] ring_pos(input logic [IdxW-1:0] head,
                                               input logic [IdxW-1:0] off);
    logic [IdxW:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= DepthIdx) begin
      sum = sum - DepthIdx;
    end
    return sum[IdxW-1:0];
  endfunction

  logic [MemW-1:0]     mem [DEPTH];
  logic [MemW-1:0]     rdata_q;

  state_e              state_d, state_q;
  logic [IdxW-1:0]     head_d, head_q;
  logic [CntW-1:0]     count_d, count_q;
  logic [CntW-1:0]     idx_d, idx_q;
  logic                rd_valid_d, rd_valid_q;
  logic [PID_BITS-1:0] key_d, key_q;
  logic                out_valid_d, out_valid_q;
  out_beat_t           out_beat_d, out_beat_q;

  logic                out_free, is_empty, is_full, needs_wait, accept;
  logic                hit, exhausted, finish;
  logic                we, re;
  logic [IdxW-1:0]     waddr, raddr;
  logic [IdxW-1:0]     head_prev;
  logic [PID_BITS-1:0] rd_pid;
  out_beat_t           res;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign is_empty  = (count_q == '0);
  assign is_full   = (count_q == DepthCnt);
  assign head_prev = (head_q == '0) ? LastIdx : head_q - IdxW'(1);
  assign rd_pid    = rdata_q[MemW-1:PayloadW];

  // Non-empty pops and searches finish in a later cycle, so they may enter
  // while an older result still waits; everything else finishes at once.
  assign needs_wait = !is_empty &&
                      ((cmd_i.op == OP_POP_FRONT) || (cmd_i.op == OP_POP_BACK) ||
                       (cmd_i.op == OP_SEARCH));
  assign cmd_stall_o = !((state_q == ST_IDLE) && (needs_wait || out_free));
  assign accept      = cmd_valid_i && !cmd_stall_o;

  assign hit       = rd_valid_q && (rd_pid == key_q);
  assign exhausted = rd_valid_q && (idx_q == count_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && needs_wait) begin
          state_d = (cmd_i.op == OP_SEARCH) ? ST_SEARCH : ST_POP;
        end
      end
      ST_POP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SEARCH: begin
        if ((hit || exhausted) && out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and result.
  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    idx_d      = idx_q;
    rd_valid_d = rd_valid_q;
    key_d      = key_q;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = head_q;
    raddr      = head_q;
    finish     = 1'b0;
    res        = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          finish = !needs_wait;
          case (cmd_i.op)
            OP_PUSH_FRONT: begin
              if (is_full) begin
                res.status = STATUS_FULL;
              end else begin
                we      = 1'b1;
                waddr   = head_prev;
                head_d  = head_prev;
                count_d = count_q + CntW'(1);
              end
            end
            OP_PUSH_BACK: begin
              if (is_full) begin
                res.status = STATUS_FULL;
              end else begin
                we      = 1'b1;
                waddr   = ring_pos(head_q, count_q[IdxW-1:0]);
                count_d = count_q + CntW'(1);
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                res.status = STATUS_EMPTY;
              end else begin
                re      = 1'b1;
                raddr   = head_q;
                head_d  = ring_pos(head_q, IdxW'(1));
                count_d = count_q - CntW'(1);
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                res.status = STATUS_EMPTY;
              end else begin
                re      = 1'b1;
                raddr   = ring_pos(head_q, IdxW'(count_q - CntW'(1)));
                count_d = count_q - CntW'(1);
              end
            end
            OP_SEARCH: begin
              idx_d      = '0;
              rd_valid_d = 1'b0;
              key_d      = PID_BITS'(cmd_i.pid);
            end
            OP_CLEAR: begin
              head_d  = '0;
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        finish          = out_free;
        res.out_pid     = PidW'(rd_pid);
        res.out_payload = rdata_q[PayloadW-1:0];
      end
      ST_SEARCH: begin
        if (hit || exhausted) begin
          finish    = out_free;
          res.found = hit;
        end else begin
          re         = 1'b1;
          raddr      = ring_pos(head_q, idx_q[IdxW-1:0]);
          idx_d      = idx_q + CntW'(1);
          rd_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.occupancy = OccW'(count_d);

    out_beat_d  = finish ? res : out_beat_q;
    out_valid_d = finish || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    out_beat_q <= out_beat_d;
  end

  // Ring store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= {PID_BITS'(cmd_i.pid), cmd_i.payload};
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

// ===== design/process_record_deque.sv =====
// ----------------------------------------------------------------------------
// Process record deque
// Bounded double-ended queue of process records with identifier search.
// ----------------------------------------------------------------------------
// Each request beat asks to push a record at the front or back, pop one from
// the front or back, search the held records for an identifier, or clear the
// queue, and every request gives exactly one result beat, in request order.
// A push into a full queue is dropped and reported as full; a pop from an
// empty queue reports empty with a zero record. Records live in a ring store
// of DEPTH entries addressed from a head register and a count. The front end
// registers and classifies a request and hands it through a two-entry command
// queue to the back end, which executes one command at a time. In the back
// end a push, a clear, an unused mode, or a pop or search on an empty queue
// finishes as soon as it is taken. A pop waits for the registered read port
// of the ring store. A search reads one held entry per cycle through that
// same port, stopping at the first hit or after the last held entry. The
// front end and the command queue add registered stages but do not slow the
// flow of requests, and a finished result sits in an output register, so new
// requests keep entering while it waits. The store is not cleared at reset;
// only entries between the head and the count are ever read.
// ----------------------------------------------------------------------------
module process_record_deque
  import prd_pkg::*;
#(
  parameter int unsigned DEPTH    = DepthDefault,
  parameter int unsigned PID_BITS = PidBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  // Classified commands from the front end into the queue.
  logic front_valid, front_stall;
  cmd_t front_cmd;

  // Commands from the queue into the back end.
  logic back_valid, back_stall;
  cmd_t back_cmd;

  // The front end decodes the mode and pins unused codes to no-operation.
  prd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .cmd_valid_o (front_valid),
    .cmd_stall_i (front_stall),
    .cmd_o       (front_cmd)
  );

  // The queue lets the front end keep taking beats while the back end is
  // busy with a pop or a search scan.
  prd_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_stall_o (front_stall),
    .wr_cmd_i   (front_cmd),
    .rd_valid_o (back_valid),
    .rd_stall_i (back_stall),
    .rd_cmd_o   (back_cmd)
  );

  // The back end owns the ring store, the head and count, and the result beat.
  prd_back #(
    .DEPTH    (DEPTH),
    .PID_BITS (PID_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_stall_o (back_stall),
    .cmd_i       (back_cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

// ===== design/prd_checker.sv =====
// ----------------------------------------------------------------------------
// Process record deque checker
// Port-level assertions on result beats, bound to the top level.
// ----------------------------------------------------------------------------
module prd_checker
  import prd_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_beat_o
);

  // A result beat that is held back stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat withdrawn while stalled");

  // A held-back result beat does not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_beat_o))
    else $error("result beat changed while stalled");

  // Empty results carry no record and report an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.status == STATUS_EMPTY) |->
      (out_beat_o.occupancy == '0) && (out_beat_o.out_pid == '0) &&
      (out_beat_o.out_payload == '0) && !out_beat_o.found)
    else $error("empty result carries data or occupancy");

  // A dropped push returns no record and no search hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.status == STATUS_FULL) |->
      (out_beat_o.out_pid == '0) && (out_beat_o.out_payload == '0) &&
      !out_beat_o.found)
    else $error("full result carries data");

  // A search hit only comes with a done status and carries no record identifier.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.found |->
      (out_beat_o.status == STATUS_DONE) && (out_beat_o.out_pid == '0))
    else $error("search hit with inconsistent status");

endmodule

bind process_record_deque prd_checker u_prd_checker (.*);
